/* sv/ers_pkg.sv */
// ----------------------------------------------------------------------------
// ers_pkg
// Shared types and constants for the edge recovery sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ers_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int DIST_W      = 16;
    localparam int TIME_W      = 32;
    localparam int SPEED_W     = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd100;
    localparam logic [SPEED_W-1:0] HOLD_SPEED = 7'd10;

    // register reset values
    localparam logic [DIST_W-1:0]  RST_EDGE_THR  = 16'd400;
    localparam logic [DIST_W-1:0]  RST_ALIGN_THR = 16'd100;
    localparam logic [15:0]        RST_HOLD_MS   = 16'd800;
    localparam logic [15:0]        RST_TURN_TAIL = 16'd530;
    localparam logic [15:0]        RST_TURN_SIDE = 16'd280;
    localparam logic [15:0]        RST_TURN_FD   = 16'd160;
    localparam logic [15:0]        RST_TURN_RD   = 16'd410;
    localparam logic [SPEED_W-1:0] RST_TURN_SPD  = 7'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_THR  = 3'd0,
        CFG_ALIGN_THR = 3'd1,
        CFG_HOLD_MS   = 3'd2,
        CFG_TURN_TAIL = 3'd3,
        CFG_TURN_SIDE = 3'd4,
        CFG_TURN_FD   = 3'd5,
        CFG_TURN_RD   = 3'd6,
        CFG_TURN_SPD  = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_START  = 2'd1,
        MODE_DETECT = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RS_IDLE      = 2'd0,
        RS_DETECTED  = 2'd1,
        RS_EXECUTING = 2'd2,
        RS_DONE      = 2'd3
    } run_state_t;

    typedef enum logic [1:0] {
        PH_INIT   = 2'd0,
        PH_TURN   = 2'd1,
        PH_HOLD   = 2'd2,
        PH_FINISH = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        DIR_NONE        = 4'd0,
        DIR_HEAD        = 4'd1,
        DIR_TAIL        = 4'd2,
        DIR_LEFT        = 4'd3,
        DIR_RIGHT       = 4'd4,
        DIR_FRONT_RIGHT = 4'd5,
        DIR_FRONT_LEFT  = 4'd6,
        DIR_REAR_LEFT   = 4'd7,
        DIR_REAR_RIGHT  = 4'd8
    } dir_t;

    typedef enum logic [2:0] {
        CMD_STOP     = 3'd0,
        CMD_FORWARD  = 3'd1,
        CMD_BACKWARD = 3'd2,
        CMD_LEFT     = 3'd3,
        CMD_RIGHT    = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [3:0]         direction;
        logic               motor_valid;
        logic [2:0]         motor_cmd;
        logic [SPEED_W-1:0] motor_speed;
        logic               active;
        logic               done_res;
    } result_t;

endpackage

/* sv/edge_recovery_sequencer.sv */
// ----------------------------------------------------------------------------
// edge_recovery_sequencer
// Edge detection over eight distance lanes plus a four-phase recovery
// sequencer (init, turn, hold, finish) driven by millisecond time stamps.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------
//  in      | in_valid / in_stall     | mode, now_ms, dist0..dist7
//  out     | out_valid / out_stall   | direction, motor_valid, motor_cmd,
//          |                         | motor_speed, active, done_res
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; each result is registered in the
//  output buffer, and a stalled output delays it until it drains.
//  Detection and the sequencer step are combinational between the input
//  transfer and the output register.
//  A two-entry output (main register plus skid) keeps input open while one
//  result waits; in_stall rises only when both entries are full.
//  cfg_ready is always high. rst_n clears sequencer state, output valids and
//  loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_recovery_sequencer
    import ers_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic [DIST_W-1:0]     dist0,
    input  logic [DIST_W-1:0]     dist1,
    input  logic [DIST_W-1:0]     dist2,
    input  logic [DIST_W-1:0]     dist3,
    input  logic [DIST_W-1:0]     dist4,
    input  logic [DIST_W-1:0]     dist5,
    input  logic [DIST_W-1:0]     dist6,
    input  logic [DIST_W-1:0]     dist7,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            direction,
    output logic                  motor_valid,
    output logic [2:0]            motor_cmd,
    output logic [SPEED_W-1:0]    motor_speed,
    output logic                  active,
    output logic                  done_res,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ---------------- configuration registers ----------------
    logic [DIST_W-1:0]  edge_thr_reg;
    logic [DIST_W-1:0]  align_thr_reg;
    logic [15:0]        hold_ms_reg;
    logic [15:0]        turn_tail_reg;
    logic [15:0]        turn_side_reg;
    logic [15:0]        turn_fd_reg;
    logic [15:0]        turn_rd_reg;
    logic [SPEED_W-1:0] turn_spd_reg;

    logic cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_thr_reg  <= RST_EDGE_THR;
            align_thr_reg <= RST_ALIGN_THR;
            hold_ms_reg   <= RST_HOLD_MS;
            turn_tail_reg <= RST_TURN_TAIL;
            turn_side_reg <= RST_TURN_SIDE;
            turn_fd_reg   <= RST_TURN_FD;
            turn_rd_reg   <= RST_TURN_RD;
            turn_spd_reg  <= RST_TURN_SPD;
        end
        else if (cfg_fire)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_EDGE_THR:  edge_thr_reg  <= cfg_data;
                CFG_ALIGN_THR: align_thr_reg <= cfg_data;
                CFG_HOLD_MS:   hold_ms_reg   <= cfg_data;
                CFG_TURN_TAIL: turn_tail_reg <= cfg_data;
                CFG_TURN_SIDE: turn_side_reg <= cfg_data;
                CFG_TURN_FD:   turn_fd_reg   <= cfg_data;
                CFG_TURN_RD:   turn_rd_reg   <= cfg_data;
                CFG_TURN_SPD:  turn_spd_reg  <= cfg_data[SPEED_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- detection lanes ----------------
    logic [DIST_W-1:0]      dist_vec [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] below;
    dir_t                   det_dir;

    assign dist_vec[0] = dist0;
    assign dist_vec[1] = dist1;
    assign dist_vec[2] = dist2;
    assign dist_vec[3] = dist3;
    assign dist_vec[4] = dist4;
    assign dist_vec[5] = dist5;
    assign dist_vec[6] = dist6;
    assign dist_vec[7] = dist7;

    for (genvar g = 0; g < NUM_SENSORS; g++)
    begin : g_lane
        ers_lane u_lane
        (
            .reading   (dist_vec[g]),
            .threshold (edge_thr_reg),
            .below     (below[g])
        );
    end

    ers_merge u_merge
    (
        .below (below),
        .dir   (det_dir)
    );

    // ---------------- output buffer: main + skid ----------------
    result_t main_reg;
    result_t skid_reg;
    logic    main_v_reg;
    logic    skid_v_reg;
    result_t res_new;
    logic    in_fire;
    logic    out_fire;

    assign in_stall = skid_v_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = main_v_reg && !out_stall;

    // ---------------- sequencer state ----------------
    run_state_t         run_state_reg, run_state_next;
    phase_t             phase_reg, phase_next;
    dir_t               edge_dir_reg, edge_dir_next;
    logic [TIME_W-1:0]  start_ms_reg, start_ms_next;
    logic               done_flag_reg, done_flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_state_reg <= RS_IDLE;
            phase_reg     <= PH_INIT;
            edge_dir_reg  <= DIR_NONE;
            start_ms_reg  <= '0;
            done_flag_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            run_state_reg <= run_state_next;
            phase_reg     <= phase_next;
            edge_dir_reg  <= edge_dir_next;
            start_ms_reg  <= start_ms_next;
            done_flag_reg <= done_flag_next;
        end
    end

    logic [TIME_W-1:0]  elapsed;
    logic [15:0]        turn_time;
    logic [SPEED_W-1:0] turn_spd;
    logic [DIST_W:0]    front_diff;
    logic               align_fwd;
    logic [3:0]         dir_out;
    logic               mv;
    cmd_t               mc;
    logic [SPEED_W-1:0] ms;

    // elapsed wraps mod 2^32
    assign elapsed    = now_ms - start_ms_reg;
    assign turn_spd   = (turn_spd_reg > SPEED_MAX) ? SPEED_MAX : turn_spd_reg;
    assign front_diff = {1'b0, dist1} - {1'b0, dist2};
    assign align_fwd  = (dist1 > dist2) && (front_diff[DIST_W-1:0] >= align_thr_reg);

    always_comb
    begin
        case (edge_dir_reg)
            DIR_TAIL:                        turn_time = turn_tail_reg;
            DIR_LEFT, DIR_RIGHT:             turn_time = turn_side_reg;
            DIR_FRONT_LEFT, DIR_FRONT_RIGHT: turn_time = turn_fd_reg;
            DIR_REAR_LEFT, DIR_REAR_RIGHT:   turn_time = turn_rd_reg;
            default:                         turn_time = '0;
        endcase
    end

    always_comb
    begin
        run_state_next = run_state_reg;
        phase_next     = phase_reg;
        edge_dir_next  = edge_dir_reg;
        start_ms_next  = start_ms_reg;
        done_flag_next = done_flag_reg;
        dir_out        = edge_dir_reg;
        mv             = 1'b0;
        mc             = CMD_STOP;
        ms             = '0;

        case (mode_t'(mode))
            MODE_START, MODE_DETECT:
            begin
                dir_out = det_dir;
                if ((mode_t'(mode) == MODE_START) && (det_dir != DIR_NONE))
                begin
                    run_state_next = RS_DETECTED;
                    edge_dir_next  = det_dir;
                    phase_next     = PH_INIT;
                    start_ms_next  = now_ms;
                    done_flag_next = 1'b0;
                end
            end
            MODE_CLEAR:
            begin
                run_state_next = RS_IDLE;
                edge_dir_next  = DIR_NONE;
                phase_next     = PH_INIT;
                start_ms_next  = '0;
                done_flag_next = 1'b0;
                dir_out        = DIR_NONE;
            end
            default:
            begin
                // update step
                case (run_state_reg)
                    RS_DETECTED:
                    begin
                        // arm and run init in the same step
                        run_state_next = RS_EXECUTING;
                        phase_next     = PH_TURN;
                        start_ms_next  = now_ms;
                    end
                    RS_EXECUTING:
                    begin
                        case (phase_reg)
                            PH_INIT:
                            begin
                                phase_next    = PH_TURN;
                                start_ms_next = now_ms;
                            end
                            PH_TURN:
                            begin
                                mv = 1'b1;
                                case (edge_dir_reg)
                                    DIR_LEFT, DIR_FRONT_LEFT, DIR_REAR_LEFT:
                                    begin
                                        mc = CMD_LEFT;
                                        ms = turn_spd;
                                    end
                                    DIR_RIGHT, DIR_TAIL, DIR_FRONT_RIGHT, DIR_REAR_RIGHT:
                                    begin
                                        mc = CMD_RIGHT;
                                        ms = turn_spd;
                                    end
                                    default:
                                    begin
                                        mc = CMD_STOP;
                                        ms = '0;
                                    end
                                endcase
                                if (elapsed >= {16'd0, turn_time})
                                begin
                                    phase_next    = PH_HOLD;
                                    start_ms_next = now_ms;
                                end
                            end
                            PH_HOLD:
                            begin
                                if (elapsed >= {16'd0, hold_ms_reg})
                                begin
                                    phase_next    = PH_FINISH;
                                    start_ms_next = now_ms;
                                end
                                else
                                begin
                                    mv = 1'b1;
                                    ms = HOLD_SPEED;
                                    mc = align_fwd ? CMD_FORWARD : CMD_BACKWARD;
                                end
                            end
                            default:
                            begin
                                run_state_next = RS_DONE;
                                done_flag_next = 1'b1;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
        endcase

        res_new.direction   = dir_out;
        res_new.motor_valid = mv;
        res_new.motor_cmd   = mc;
        res_new.motor_speed = ms;
        res_new.active      = (run_state_next == RS_DETECTED) ||
                              (run_state_next == RS_EXECUTING);
        res_new.done_res    = done_flag_next;
    end

    // main register refills from skid first so order is kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!main_v_reg || out_fire)
        begin
            if (skid_v_reg)
            begin
                main_v_reg <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                main_v_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_v_reg || out_fire)
        begin
            main_reg <= skid_v_reg ? skid_reg : res_new;
        end
        else if (in_fire)
        begin
            skid_reg <= res_new;
        end
    end

    assign out_valid   = main_v_reg;
    assign direction   = main_reg.direction;
    assign motor_valid = main_reg.motor_valid;
    assign motor_cmd   = main_reg.motor_cmd;
    assign motor_speed = main_reg.motor_speed;
    assign active      = main_reg.active;
    assign done_res    = main_reg.done_res;

`ifndef SYNTHESIS
    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg)
        else $error("skid entry held without main entry");

    a_done_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        done_flag_reg == (run_state_reg == RS_DONE))
        else $error("done flag out of step with run state");

    a_exec_not_init: assert property (@(posedge clk) disable iff (!rst_n)
        (run_state_reg == RS_EXECUTING) |-> (phase_reg != PH_INIT))
        else $error("executing run parked in init phase");

    a_clear_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (mode == MODE_CLEAR)) |=> (run_state_reg == RS_IDLE))
        else $error("clear did not return sequencer to idle");
`endif

endmodule

/* sv/ers_lane.sv */
// ----------------------------------------------------------------------------
// ers_lane
// One sensor lane: strict below-threshold edge test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ers_lane
    import ers_pkg::*;
(
    input  logic [DIST_W-1:0] reading,
    input  logic [DIST_W-1:0] threshold,
    output logic              below
);

    assign below = (reading < threshold);

endmodule

/* sv/ers_merge.sv */
// ----------------------------------------------------------------------------
// ers_merge
// Combines lane hits into one edge direction by fixed priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ers_merge
    import ers_pkg::*;
(
    input  logic [NUM_SENSORS-1:0] below,
    output dir_t                   dir
);

    always_comb
    begin
        if (below[1] && below[2])
        begin
            dir = DIR_TAIL;
        end
        else if (below[3] && below[4])
        begin
            dir = DIR_LEFT;
        end
        else if (below[5])
        begin
            dir = DIR_FRONT_LEFT;
        end
        else if (below[0])
        begin
            dir = DIR_FRONT_RIGHT;
        end
        else if (below[7])
        begin
            dir = DIR_REAR_LEFT;
        end
        else if (below[6])
        begin
            dir = DIR_REAR_RIGHT;
        end
        else
        begin
            dir = DIR_NONE;
        end
    end

endmodule
